/* rtl/tha_pkg.sv */
package tha_pkg;

    // Request codes carried on req_type
    localparam logic [2:0] REQ_NEW_TARGET = 3'd0;
    localparam logic [2:0] REQ_ACK_TARGET = 3'd1;
    localparam logic [2:0] REQ_RESULT     = 3'd2;
    localparam logic [2:0] REQ_PING       = 3'd3;
    localparam logic [2:0] REQ_PONG       = 3'd4;
    localparam logic [2:0] REQ_TICK       = 3'd5;
    localparam logic [2:0] REQ_LINK_UP    = 3'd6;
    localparam logic [2:0] REQ_LINK_DOWN  = 3'd7;

    // Action codes carried on action
    localparam logic [2:0] ACT_SEND_TARGET = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK    = 3'd1;
    localparam logic [2:0] ACT_PUBLISH     = 3'd2;
    localparam logic [2:0] ACT_SEND_PONG   = 3'd3;
    localparam logic [2:0] ACT_SEND_PING   = 3'd4;
    localparam logic [2:0] ACT_DISCONNECT  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_HB_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_HB_TIMEOUT  = 2'd3;

    // Configuration reset values
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
    localparam logic [15:0] HB_INTERVAL_RST = 16'd1000;
    localparam logic [16:0] HB_TIMEOUT_RST  = 17'd3000;

    localparam logic [15:0] TIMER16_MAX = 16'hFFFF;
    localparam logic [16:0] SILENCE_MAX = 17'h1FFFF;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One outgoing result
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [7:0]  target;
        logic [7:0]  status;
    } t_result;

    // Results caused by one accepted transaction (one or two)
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    function automatic t_result make_res(logic [2:0] act, logic [31:0] seq,
                                         logic [7:0] tgt, logic [7:0] st);
        t_result r;
        r.action = act;
        r.seq    = seq;
        r.target = tgt;
        r.status = st;
        return r;
    endfunction

endpackage

/* rtl/task_handoff_arq_with_heartbeat.sv */
// A result passes through the queue and then the output register once its transaction is accepted.
// Throughput: one transaction per cycle while the queue has room, and one result per cycle
// while the output is taken; a transaction with two results sends them one after the other.
// A four-entry queue between the classifying front and the output back absorbs stalls.
// Reset is synchronous and active low: timers, flags and queue clear, both sequence
// counters return to one and the configuration registers to their defaults.
module task_handoff_arq_with_heartbeat #(
    parameter int SEQ_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_seq_in,
    input  logic [7:0]  i_target_code,
    input  logic [7:0]  i_status_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [31:0] o_seq_out,
    output logic [7:0]  o_target_out,
    output logic [7:0]  o_status_out,
    output logic        o_last
);
    import tha_pkg::*;

    logic   w_push, w_full, w_q_valid, w_pop;
    t_entry w_entry, w_head;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // Front: classifies transactions, keeps the protocol state
    tha_front #(
        .SEQ_WIDTH(SEQ_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_seq_in      (i_seq_in),
        .i_target_code (i_target_code),
        .i_status_code (i_status_code),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    // Queue of pending result groups
    tha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Back: sends results one at a time
    tha_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_head     (w_head),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_action     (o_action),
        .o_seq_out    (o_seq_out),
        .o_target_out (o_target_out),
        .o_status_out (o_status_out),
        .o_last       (o_last)
    );

endmodule

/* rtl/tha_front.sv */
module tha_front #(
    parameter int SEQ_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [16:0]     i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_req_type,
    input  logic [31:0]     i_seq_in,
    input  logic [7:0]      i_target_code,
    input  logic [7:0]      i_status_code,
    input  logic            i_q_full,
    output logic            o_push,
    output tha_pkg::t_entry o_entry
);
    import tha_pkg::*;

    // Configuration registers
    logic [15:0] r_ack_timeout;
    logic [7:0]  r_max_retries;
    logic [15:0] r_hb_interval;
    logic [16:0] r_hb_timeout;

    // Protocol state
    logic [SEQ_WIDTH-1:0] r_next_seq, n_next_seq;
    logic                 r_task_busy, n_task_busy;
    logic                 r_awaiting, n_awaiting;
    logic [SEQ_WIDTH-1:0] r_active_seq, n_active_seq;
    logic [7:0]           r_active_target, n_active_target;
    logic [7:0]           r_resend_cnt, n_resend_cnt;
    logic [15:0]          r_ack_wait, n_ack_wait;
    logic                 r_done_valid, n_done_valid;
    logic [SEQ_WIDTH-1:0] r_done_seq, n_done_seq;
    logic                 r_link_up, n_link_up;
    logic [16:0]          r_silence, n_silence;
    logic [15:0]          r_ping_elapsed, n_ping_elapsed;
    logic                 r_ping_once, n_ping_once;
    logic [SEQ_WIDTH-1:0] r_ping_seq, n_ping_seq;

    logic [63:0]          w_seq_in64;
    logic [SEQ_WIDTH-1:0] w_seq;
    logic [63:0]          w_active64, w_ping64, w_seq64;
    logic                 w_accept;
    logic [15:0]          w_ack_inc, w_ping_inc;
    logic [16:0]          w_sil_inc;
    logic                 w_ack_expire, w_ack_disc, w_hb_disc, w_ping_fire;
    logic                 w_a_valid, w_b_valid;
    t_result              w_a, w_b;
    t_entry               w_entry;
    logic                 w_any;

    // The incoming sequence is compared in its low SEQ_WIDTH bits
    assign w_seq_in64 = {32'd0, i_seq_in};
    assign w_seq      = w_seq_in64[SEQ_WIDTH-1:0];
    assign w_active64 = 64'(r_active_seq);
    assign w_ping64   = 64'(r_ping_seq);
    assign w_seq64    = 64'(w_seq);

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Saturating timer increments and tick decisions
    assign w_ack_inc    = (r_ack_wait < TIMER16_MAX) ? r_ack_wait + 16'd1 : r_ack_wait;
    assign w_ping_inc   = (r_ping_elapsed < TIMER16_MAX) ? r_ping_elapsed + 16'd1
                                                         : r_ping_elapsed;
    assign w_sil_inc    = (r_silence < SILENCE_MAX) ? r_silence + 17'd1 : r_silence;
    assign w_ack_expire = r_task_busy && r_awaiting && (w_ack_inc >= r_ack_timeout);
    assign w_ack_disc   = w_ack_expire && (r_resend_cnt >= r_max_retries);
    assign w_hb_disc    = w_sil_inc > r_hb_timeout;
    assign w_ping_fire  = !r_ping_once || (w_ping_inc >= r_hb_interval);

    // Next state and the results of this transaction
    always_comb begin
        n_next_seq      = r_next_seq;
        n_task_busy     = r_task_busy;
        n_awaiting      = r_awaiting;
        n_active_seq    = r_active_seq;
        n_active_target = r_active_target;
        n_resend_cnt    = r_resend_cnt;
        n_ack_wait      = r_ack_wait;
        n_done_valid    = r_done_valid;
        n_done_seq      = r_done_seq;
        n_link_up       = r_link_up;
        n_silence       = r_silence;
        n_ping_elapsed  = r_ping_elapsed;
        n_ping_once     = r_ping_once;
        n_ping_seq      = r_ping_seq;
        w_a_valid       = 1'b0;
        w_b_valid       = 1'b0;
        w_a             = make_res(ACT_SEND_TARGET, 32'd0, 8'd0, 8'd0);
        w_b             = make_res(ACT_SEND_TARGET, 32'd0, 8'd0, 8'd0);

        // Received messages are dropped while the link is down
        if ((i_req_type == REQ_ACK_TARGET || i_req_type == REQ_RESULT ||
             i_req_type == REQ_PING || i_req_type == REQ_PONG) && r_link_up) begin
            n_silence = '0;
        end

        unique case (i_req_type)
            REQ_NEW_TARGET: begin
                if (!r_task_busy) begin
                    n_active_seq    = r_next_seq;
                    n_next_seq      = r_next_seq + 1'b1;
                    n_active_target = i_target_code;
                    n_task_busy     = 1'b1;
                    n_awaiting      = 1'b1;
                    n_resend_cnt    = '0;
                    n_ack_wait      = '0;
                    if (r_link_up) begin
                        w_a_valid = 1'b1;
                        w_a = make_res(ACT_SEND_TARGET, w_seq_in64[31:0] & 32'd0
                                       | 32'(r_next_seq), i_target_code, 8'd0);
                    end
                end
            end
            REQ_ACK_TARGET: begin
                if (r_link_up && r_task_busy && r_awaiting && w_seq == r_active_seq) begin
                    n_awaiting   = 1'b0;
                    n_resend_cnt = '0;
                end
            end
            REQ_RESULT: begin
                if (r_link_up) begin
                    if (r_task_busy && w_seq == r_active_seq) begin
                        n_task_busy  = 1'b0;
                        n_awaiting   = 1'b0;
                        n_done_valid = 1'b1;
                        n_done_seq   = w_seq;
                        w_a_valid    = 1'b1;
                        w_a = make_res(ACT_SEND_ACK, w_seq64[31:0], 8'd0, 8'd0);
                        w_b_valid    = 1'b1;
                        w_b = make_res(ACT_PUBLISH, w_seq64[31:0], 8'd0, i_status_code);
                    end else if (r_done_valid && w_seq == r_done_seq) begin
                        w_a_valid = 1'b1;
                        w_a = make_res(ACT_SEND_ACK, w_seq64[31:0], 8'd0, 8'd0);
                    end
                end
            end
            REQ_PING: begin
                if (r_link_up) begin
                    w_a_valid = 1'b1;
                    w_a = make_res(ACT_SEND_PONG, w_seq64[31:0], 8'd0, 8'd0);
                end
            end
            REQ_PONG: begin
                // Only clears the silence counter
            end
            REQ_TICK: begin
                if (r_link_up) begin
                    // Acknowledge timer first; its disconnect ends the tick
                    if (r_task_busy && r_awaiting) begin
                        n_ack_wait = w_ack_inc;
                    end
                    if (w_ack_expire) begin
                        n_ack_wait = '0;
                        w_a_valid  = 1'b1;
                        if (w_ack_disc) begin
                            n_link_up = 1'b0;
                            w_a = make_res(ACT_DISCONNECT, w_active64[31:0], 8'd0, 8'd0);
                        end else begin
                            n_resend_cnt = r_resend_cnt + 8'd1;
                            w_a = make_res(ACT_SEND_TARGET, w_active64[31:0],
                                           r_active_target, 8'd0);
                        end
                    end
                    // Heartbeat supervision
                    if (!w_ack_disc) begin
                        n_silence = w_sil_inc;
                        if (w_hb_disc) begin
                            n_link_up = 1'b0;
                            w_b_valid = 1'b1;
                            w_b = make_res(ACT_DISCONNECT, 32'd0, 8'd0, 8'd0);
                        end else begin
                            n_ping_elapsed = w_ping_inc;
                            if (w_ping_fire) begin
                                w_b_valid      = 1'b1;
                                w_b = make_res(ACT_SEND_PING, w_ping64[31:0], 8'd0, 8'd0);
                                n_ping_seq     = r_ping_seq + 1'b1;
                                n_ping_elapsed = '0;
                                n_ping_once    = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_LINK_UP: begin
                if (!r_link_up) begin
                    n_link_up      = 1'b1;
                    n_silence      = '0;
                    n_ping_elapsed = '0;
                    n_ping_once    = 1'b0;
                    if (r_task_busy && r_awaiting) begin
                        n_resend_cnt = '0;
                        n_ack_wait   = '0;
                        w_a_valid    = 1'b1;
                        w_a = make_res(ACT_SEND_TARGET, w_active64[31:0],
                                       r_active_target, 8'd0);
                    end
                end
            end
            REQ_LINK_DOWN: begin
                n_link_up = 1'b0;
            end
        endcase
    end

    // Pack the one or two results, earliest first
    always_comb begin
        w_any         = w_a_valid || w_b_valid;
        w_entry.two   = w_a_valid && w_b_valid;
        w_entry.r0    = w_a_valid ? w_a : w_b;
        w_entry.r1    = w_b;
    end

    assign o_push  = w_accept && w_any;
    assign o_entry = w_entry;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_max_retries <= MAX_RETRIES_RST;
            r_hb_interval <= HB_INTERVAL_RST;
            r_hb_timeout  <= HB_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[15:0];
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data[7:0];
                CFG_HB_INTERVAL: r_hb_interval <= i_cfg_data[15:0];
                CFG_HB_TIMEOUT:  r_hb_timeout  <= i_cfg_data;
            endcase
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq      <= SEQ_WIDTH'(1);
            r_task_busy     <= 1'b0;
            r_awaiting      <= 1'b0;
            r_active_seq    <= '0;
            r_active_target <= '0;
            r_resend_cnt    <= '0;
            r_ack_wait      <= '0;
            r_done_valid    <= 1'b0;
            r_done_seq      <= '0;
            r_link_up       <= 1'b0;
            r_silence       <= '0;
            r_ping_elapsed  <= '0;
            r_ping_once     <= 1'b0;
            r_ping_seq      <= SEQ_WIDTH'(1);
        end else if (w_accept) begin
            r_next_seq      <= n_next_seq;
            r_task_busy     <= n_task_busy;
            r_awaiting      <= n_awaiting;
            r_active_seq    <= n_active_seq;
            r_active_target <= n_active_target;
            r_resend_cnt    <= n_resend_cnt;
            r_ack_wait      <= n_ack_wait;
            r_done_valid    <= n_done_valid;
            r_done_seq      <= n_done_seq;
            r_link_up       <= n_link_up;
            r_silence       <= n_silence;
            r_ping_elapsed  <= n_ping_elapsed;
            r_ping_once     <= n_ping_once;
            r_ping_seq      <= n_ping_seq;
        end
    end

endmodule

/* rtl/tha_queue.sv */
module tha_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tha_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tha_pkg::t_entry o_head
);
    import tha_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   w_do_push, w_do_pop;

    assign o_full    = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/tha_back.sv */
module tha_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tha_pkg::t_entry i_q_head,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_action,
    output logic [31:0]     o_seq_out,
    output logic [7:0]      o_target_out,
    output logic [7:0]      o_status_out,
    output logic            o_last
);
    import tha_pkg::*;

    logic    r_out_valid;
    logic    r_sub;
    t_result r_res;
    logic    r_last;
    logic    w_load;
    logic    w_final;
    t_result w_pick;

    // The output register takes a new result when empty or being taken
    assign w_load  = i_q_valid && (!r_out_valid || i_ready);
    assign w_final = !i_q_head.two || r_sub;
    assign w_pick  = r_sub ? i_q_head.r1 : i_q_head.r0;
    assign o_q_pop = w_load && w_final;

    // Control: output valid and which half of a two-result entry is next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_sub       <= !w_final;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res  <= w_pick;
            r_last <= w_final;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_action     = r_res.action;
    assign o_seq_out    = r_res.seq;
    assign o_target_out = r_res.target;
    assign o_status_out = r_res.status;
    assign o_last       = r_last;

endmodule

/* tb/handoff_checker.sv */
module handoff_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_seq_in,
    input  logic [7:0]  i_target_code,
    input  logic [7:0]  i_status_code,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_seq_out,
    input  logic [7:0]  i_target_out,
    input  logic [7:0]  i_status_out,
    input  logic        i_last,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_handled,
    output logic [31:0] o_active_seq,
    output logic [31:0] o_done_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    import tha_pkg::*;

    // One expected result as it should leave the block.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [7:0]  target;
        logic [7:0]  status;
        logic        last;
    } t_handoff_res;

    t_handoff_res pending_results[$];
    t_handoff_res staged[2];
    int           n_staged;
    int unsigned  fail_count;
    int unsigned  handled_count;

    // Configuration as the block should hold it.
    logic [15:0] cfg_ack_to;
    logic [7:0]  cfg_retries;
    logic [15:0] cfg_hb_interval;
    logic [16:0] cfg_hb_timeout;

    // Protocol state of the handoff engine.
    logic [31:0] task_seq_next;
    logic        task_active;
    logic        ack_pending;
    logic [31:0] cur_seq;
    logic [7:0]  cur_target;
    logic [7:0]  resends;
    logic [15:0] ack_wait;
    logic        have_done;
    logic [31:0] done_id;
    logic        link_up;
    logic [16:0] quiet_ticks;
    logic [15:0] ping_age;
    logic        ping_started;
    logic [31:0] ping_id;

    // Prints one line per mismatch and counts it.
    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic stage(input logic [2:0] act, input logic [31:0] sq,
                         input logic [7:0] tgt, input logic [7:0] st);
        if (n_staged < 2) begin
            staged[n_staged].action = act;
            staged[n_staged].seq    = sq;
            staged[n_staged].target = tgt;
            staged[n_staged].status = st;
            staged[n_staged].last   = 1'b0;
            n_staged++;
        end
    endtask

    // Works out the results of one transaction and advances the protocol state.
    task automatic predict_handoff(input logic [2:0] rq, input logic [31:0] sq,
                                   input logic [7:0] tc, input logic [7:0] sc);
        // Received messages are dropped while the link is down and otherwise end the silence.
        if (rq >= REQ_ACK_TARGET && rq <= REQ_PONG) begin
            if (!link_up) return;
            quiet_ticks = '0;
        end
        case (rq)
            REQ_NEW_TARGET: begin
                if (!task_active) begin
                    cur_seq       = task_seq_next;
                    task_seq_next = task_seq_next + 32'd1;
                    cur_target    = tc;
                    task_active   = 1'b1;
                    ack_pending   = 1'b1;
                    resends       = '0;
                    ack_wait      = '0;
                    if (link_up) stage(ACT_SEND_TARGET, cur_seq, cur_target, 8'd0);
                end
            end
            REQ_ACK_TARGET: begin
                if (task_active && ack_pending && sq == cur_seq) begin
                    ack_pending = 1'b0;
                    resends     = '0;
                end
            end
            REQ_RESULT: begin
                if (task_active && sq == cur_seq) begin
                    task_active = 1'b0;
                    ack_pending = 1'b0;
                    have_done   = 1'b1;
                    done_id     = sq;
                    stage(ACT_SEND_ACK, sq, 8'd0, 8'd0);
                    stage(ACT_PUBLISH, sq, 8'd0, sc);
                end else if (have_done && sq == done_id) begin
                    stage(ACT_SEND_ACK, sq, 8'd0, 8'd0);
                end
            end
            REQ_PING: stage(ACT_SEND_PONG, sq, 8'd0, 8'd0);
            REQ_PONG: ;
            REQ_TICK: begin
                if (!link_up) return;
                // The acknowledge timer goes first; its disconnect ends the tick.
                if (task_active && ack_pending) begin
                    if (ack_wait < TIMER16_MAX) ack_wait = ack_wait + 16'd1;
                    if (ack_wait >= cfg_ack_to) begin
                        ack_wait = '0;
                        if (resends >= cfg_retries) begin
                            link_up = 1'b0;
                            stage(ACT_DISCONNECT, cur_seq, 8'd0, 8'd0);
                            return;
                        end
                        resends = resends + 8'd1;
                        stage(ACT_SEND_TARGET, cur_seq, cur_target, 8'd0);
                    end
                end
                if (quiet_ticks < SILENCE_MAX) quiet_ticks = quiet_ticks + 17'd1;
                if (quiet_ticks > cfg_hb_timeout) begin
                    link_up = 1'b0;
                    stage(ACT_DISCONNECT, 32'd0, 8'd0, 8'd0);
                    return;
                end
                if (ping_age < TIMER16_MAX) ping_age = ping_age + 16'd1;
                if (!ping_started || ping_age >= cfg_hb_interval) begin
                    stage(ACT_SEND_PING, ping_id, 8'd0, 8'd0);
                    ping_id      = ping_id + 32'd1;
                    ping_age     = '0;
                    ping_started = 1'b1;
                end
            end
            REQ_LINK_UP: begin
                if (link_up) return;
                link_up      = 1'b1;
                quiet_ticks  = '0;
                ping_age     = '0;
                ping_started = 1'b0;
                if (task_active && ack_pending) begin
                    resends  = '0;
                    ack_wait = '0;
                    stage(ACT_SEND_TARGET, cur_seq, cur_target, 8'd0);
                end
            end
            default: link_up = 1'b0;
        endcase
    endtask

    // Watches all three channels, keeps the expected results and compares.
    always @(posedge i_clk) begin : monitor
        t_handoff_res want;
        if (!i_rst_n) begin
            cfg_ack_to      = ACK_TIMEOUT_RST;
            cfg_retries     = MAX_RETRIES_RST;
            cfg_hb_interval = HB_INTERVAL_RST;
            cfg_hb_timeout  = HB_TIMEOUT_RST;
            task_seq_next   = 32'd1;
            task_active     = 1'b0;
            ack_pending     = 1'b0;
            cur_seq         = '0;
            cur_target      = '0;
            resends         = '0;
            ack_wait        = '0;
            have_done       = 1'b0;
            done_id         = '0;
            link_up         = 1'b0;
            quiet_ticks     = '0;
            ping_age        = '0;
            ping_started    = 1'b0;
            ping_id         = 32'd1;
            fail_count      = 0;
            handled_count   = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACK_TIMEOUT: cfg_ack_to      = i_cfg_data[15:0];
                    CFG_MAX_RETRIES: cfg_retries     = i_cfg_data[7:0];
                    CFG_HB_INTERVAL: cfg_hb_interval = i_cfg_data[15:0];
                    CFG_HB_TIMEOUT:  cfg_hb_timeout  = i_cfg_data;
                    default: ;
                endcase
            end

            // Results are checked before this edge's transaction is predicted.
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("unexpected result: action %0d seq %0h",
                                           i_action, i_seq_out));
                end else begin
                    want = pending_results.pop_front();
                    if (i_action !== want.action)
                        report_error($sformatf("action: got %0d, expected %0d",
                                               i_action, want.action));
                    if (i_seq_out !== want.seq)
                        report_error($sformatf("seq_out: got %0h, expected %0h",
                                               i_seq_out, want.seq));
                    if (i_target_out !== want.target)
                        report_error($sformatf("target_out: got %0h, expected %0h",
                                               i_target_out, want.target));
                    if (i_status_out !== want.status)
                        report_error($sformatf("status_out: got %0h, expected %0h",
                                               i_status_out, want.status));
                    if (i_last !== want.last)
                        report_error($sformatf("last: got %0b, expected %0b",
                                               i_last, want.last));
                end
            end

            if (i_in_valid && i_in_ready) begin
                // Every accepted transaction is counted.
                handled_count++;
                n_staged = 0;
                predict_handoff(i_req_type, i_seq_in, i_target_code, i_status_code);
                for (int k = 0; k < n_staged; k++) begin
                    staged[k].last = (k == n_staged - 1);
                    pending_results = {pending_results, staged[k]};
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_handled    <= handled_count;
        o_active_seq <= cur_seq;
        o_done_seq   <= done_id;
    end

endmodule

/* tb/tb_task_handoff_arq_with_heartbeat.sv */
module tb_task_handoff_arq_with_heartbeat;
    timeunit 1ns;
    timeprecision 1ps;

    import tha_pkg::*;

    // Where a transaction takes its sequence number from.
    typedef enum logic [1:0] {PICK_GIVEN, PICK_ACTIVE, PICK_DONE, PICK_NEAR} t_seq_pick;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_ACK_TIMEOUT;
    logic [16:0] i_cfg_data    = '0;
    logic        i_valid       = 1'b0;
    logic [2:0]  i_req_type    = REQ_TICK;
    logic [31:0] i_seq_in      = '0;
    logic [7:0]  i_target_code = '0;
    logic [7:0]  i_status_code = '0;
    logic        i_ready       = 1'b0;
    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_action;
    logic [31:0] o_seq_out;
    logic [7:0]  o_target_out;
    logic [7:0]  o_status_out;
    logic        o_last;

    int unsigned chk_fails;
    int unsigned chk_pending;
    int unsigned chk_handled;
    logic [31:0] chk_active_seq;
    logic [31:0] chk_done_seq;

    logic        quiet      = 1'b0;
    int unsigned stall_left = 0;

    task_handoff_arq_with_heartbeat u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_seq_in      (i_seq_in),
        .i_target_code (i_target_code),
        .i_status_code (i_status_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_action      (o_action),
        .o_seq_out     (o_seq_out),
        .o_target_out  (o_target_out),
        .o_status_out  (o_status_out),
        .o_last        (o_last)
    );

    handoff_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_req_type    (i_req_type),
        .i_seq_in      (i_seq_in),
        .i_target_code (i_target_code),
        .i_status_code (i_status_code),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_action      (o_action),
        .i_seq_out     (o_seq_out),
        .i_target_out  (o_target_out),
        .i_status_out  (o_status_out),
        .i_last        (o_last),
        .o_fail_count  (chk_fails),
        .o_pending     (chk_pending),
        .o_handled     (chk_handled),
        .o_active_seq  (chk_active_seq),
        .o_done_seq    (chk_done_seq)
    );

    always #4 i_clk = ~i_clk;

    // Hard limit on the run time.
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random back-pressure unless the phase runs without idling.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left <= draw_gap();
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Sends one transaction and returns at the edge that accepts it.
    task automatic send_req(input logic [2:0] rq, input t_seq_pick pick,
                            input logic [31:0] given, input logic [7:0] tc,
                            input logic [7:0] sc);
        int unsigned gap;
        logic [31:0] sq;
        gap = quiet ? 0 : draw_gap();
        // A sequence taken from the checker must see the previous transaction applied.
        if (pick != PICK_GIVEN && gap == 0) gap = 1;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        case (pick)
            PICK_ACTIVE: sq = chk_active_seq;
            PICK_DONE:   sq = chk_done_seq;
            PICK_NEAR: begin
                sq = ($urandom_range(0, 1) == 0) ? chk_active_seq : chk_done_seq;
                case ($urandom_range(0, 2))
                    0:       sq = sq + 32'd1;
                    1:       sq = sq - 32'd1;
                    default: sq = sq ^ (32'd1 << $urandom_range(0, 31));
                endcase
            end
            default: sq = given;
        endcase
        i_valid       <= 1'b1;
        i_req_type    <= rq;
        i_seq_in      <= sq;
        i_target_code <= tc;
        i_status_code <= sc;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_req(REQ_TICK, PICK_GIVEN, $urandom(), rnd8(), rnd8());
    endtask

    task automatic send_any(input int unsigned max_type);
        t_seq_pick pick;
        pick = t_seq_pick'($urandom_range(0, 3));
        send_req(3'($urandom_range(0, max_type)), pick, $urandom(), rnd8(), rnd8());
    endtask

    // Holds the sender back until every expected result has been seen.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // New register settings, written only once the block has gone idle.
    task automatic apply_settings(input logic [15:0] ack_to, input logic [7:0] retries,
                                  input logic [15:0] hb_int, input logic [16:0] hb_to);
        drain_results();
        // Transactions without results may still be in the pipeline.
        repeat (8) @(posedge i_clk);
        cfg_write(CFG_ACK_TIMEOUT, 17'(ack_to));
        cfg_write(CFG_MAX_RETRIES, 17'(retries));
        cfg_write(CFG_HB_INTERVAL, 17'(hb_int));
        cfg_write(CFG_HB_TIMEOUT, hb_to);
        i_cfg_valid <= 1'b0;
    endtask

    // One randomly chosen protocol scenario.
    task automatic run_sequence();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            // Full handoff: target out, acknowledge, result and sometimes a repeat of it.
            send_req(REQ_LINK_UP, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_req(REQ_NEW_TARGET, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_ticks($urandom_range(0, 4));
            if ($urandom_range(0, 4) != 0)
                send_req(REQ_ACK_TARGET, PICK_ACTIVE, 32'd0, rnd8(), rnd8());
            else
                send_req(REQ_ACK_TARGET, PICK_NEAR, 32'd0, rnd8(), rnd8());
            send_ticks($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                send_req(REQ_PING, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_req(REQ_RESULT, PICK_ACTIVE, 32'd0, rnd8(), rnd8());
            if ($urandom_range(0, 1) == 0)
                send_req(REQ_RESULT, PICK_DONE, 32'd0, rnd8(), rnd8());
        end else if (r < 50) begin
            // Unacknowledged target left to the resend timer.
            send_req(REQ_LINK_UP, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_req(REQ_NEW_TARGET, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_ticks($urandom_range(1, 40));
        end else if (r < 60) begin
            send_req(REQ_PING, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_req(REQ_PONG, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            send_req(REQ_PING, PICK_NEAR, 32'd0, rnd8(), rnd8());
        end else if (r < 72) begin
            // Link drops, traffic arrives while it is down, then it comes back.
            send_req(REQ_LINK_DOWN, PICK_GIVEN, $urandom(), rnd8(), rnd8());
            repeat ($urandom_range(1, 3)) send_any(REQ_PONG);
            send_ticks($urandom_range(0, 2));
            send_req(REQ_LINK_UP, PICK_GIVEN, $urandom(), rnd8(), rnd8());
        end else if (r < 82) begin
            send_ticks($urandom_range(1, 25));
        end else if (r < 92) begin
            repeat ($urandom_range(1, 4)) send_any(REQ_LINK_DOWN);
        end else if (r < 96) begin
            drain_results();
        end else begin
            send_req(REQ_ACK_TARGET, PICK_NEAR, 32'd0, rnd8(), rnd8());
            send_req(REQ_RESULT, PICK_NEAR, 32'd0, rnd8(), rnd8());
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int unsigned phase;
        logic [15:0] s_ack;
        logic [7:0]  s_ret;
        logic [15:0] s_hbi;
        logic [16:0] s_hbt;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings, starting with the link down.
        send_req(REQ_PING,       PICK_GIVEN, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_req(REQ_TICK,       PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_NEW_TARGET, PICK_GIVEN, 32'h0,         8'hFF, 8'h00);
        send_req(REQ_NEW_TARGET, PICK_GIVEN, 32'hFFFF_FFFF, 8'h00, 8'hFF);
        send_req(REQ_LINK_UP,    PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_LINK_UP,    PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_ACK_TARGET, PICK_GIVEN, 32'd2,         8'h00, 8'h00);
        send_req(REQ_ACK_TARGET, PICK_GIVEN, 32'd1,         8'h00, 8'h00);
        send_req(REQ_RESULT,     PICK_GIVEN, 32'hFFFF_FFFF, 8'h00, 8'hFF);
        send_req(REQ_RESULT,     PICK_GIVEN, 32'd1,         8'h00, 8'hFF);
        send_req(REQ_RESULT,     PICK_GIVEN, 32'd1,         8'hFF, 8'h00);
        send_req(REQ_PING,       PICK_GIVEN, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_req(REQ_PING,       PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_PONG,       PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_TICK,       PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_TICK,       PICK_GIVEN, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_req(REQ_NEW_TARGET, PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_LINK_DOWN,  PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_RESULT,     PICK_GIVEN, 32'd2,         8'h00, 8'h55);
        send_req(REQ_LINK_UP,    PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_TICK,       PICK_GIVEN, 32'h0,         8'h00, 8'h00);
        send_req(REQ_RESULT,     PICK_GIVEN, 32'd2,         8'h00, 8'h00);
        send_req(REQ_LINK_DOWN,  PICK_GIVEN, 32'h0,         8'h00, 8'h00);

        // Random part, one register setting per phase, extremes first.
        phase = 0;
        while (chk_handled < 850) begin
            case (phase)
                0: begin s_ack = 16'd0;     s_ret = 8'd0;   s_hbi = 16'd0;     s_hbt = 17'd0;      end
                1: begin s_ack = 16'hFFFF;  s_ret = 8'hFF;  s_hbi = 16'hFFFF;  s_hbt = 17'h1FFFF;  end
                2: begin s_ack = 16'd1;     s_ret = 8'd1;   s_hbi = 16'd2;     s_hbt = 17'd12;     end
                3: begin s_ack = 16'd3;     s_ret = 8'd2;   s_hbi = 16'd5;     s_hbt = 17'd40;     end
                4: begin s_ack = 16'd50;    s_ret = 8'd1;   s_hbi = 16'd200;   s_hbt = 17'd400;    end
                default: begin
                    s_ack = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(50, 70))
                                                        : 16'($urandom_range(0, 8));
                    s_ret = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
                    s_hbi = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(200, 260))
                                                        : 16'($urandom_range(0, 12));
                    s_hbt = 17'($urandom_range(0, 60));
                end
            endcase
            quiet <= ($urandom_range(0, 3) == 0);
            apply_settings(s_ack, s_ret, s_hbi, s_hbt);
            if (s_hbt >= 17'd400 && s_hbt <= 17'd450) begin
                // Close any open task, then let the receive side fall silent.
                send_req(REQ_LINK_UP, PICK_GIVEN, $urandom(), rnd8(), rnd8());
                send_req(REQ_RESULT, PICK_ACTIVE, 32'd0, rnd8(), rnd8());
                send_ticks(int'(s_hbt) + 3);
            end
            repeat ($urandom_range(5, 10)) run_sequence();
            phase++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tha_pkg.sv
rtl/tha_front.sv
rtl/tha_queue.sv
rtl/tha_back.sv
rtl/task_handoff_arq_with_heartbeat.sv
tb/handoff_checker.sv
tb/tb_task_handoff_arq_with_heartbeat.sv
